// ===== rtl/u8dec_pkg.sv =====
`timescale 1ns / 1ps

package u8dec_pkg;

   localparam int unsigned BYTE_BITS      = 8;
   localparam int unsigned CP_BITS        = 26;
   localparam int unsigned LEFT_BITS      = 3;
   localparam int unsigned OUT_COUNT_BITS = 16;
   localparam int unsigned MAX_CHAR_BITS  = 16;
   localparam int unsigned CONT_BITS      = 6;

   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = '1;

   // continuation bytes still expected after each kind of lead byte
   localparam logic [LEFT_BITS-1:0] LEFT_NONE  = 3'd0;
   localparam logic [LEFT_BITS-1:0] LEFT_TWO   = 3'd1;
   localparam logic [LEFT_BITS-1:0] LEFT_THREE = 3'd2;
   localparam logic [LEFT_BITS-1:0] LEFT_FOUR  = 3'd3;
   localparam logic [LEFT_BITS-1:0] LEFT_FIVE  = 3'd4;

   typedef struct packed {
      logic [BYTE_BITS-1:0] in_byte;
      logic                 end_of_string;
   } req_type;

   typedef struct packed {
      logic [CP_BITS-1:0]        code_point;
      logic                      char_valid;
      logic                      last;
      logic [OUT_COUNT_BITS-1:0] char_count;
   } rsp_type;

   typedef struct packed {
      logic [LEFT_BITS-1:0] bytes_left;
      logic [CP_BITS-1:0]   accumulator;
      logic                 stopped;
   } seq_state_type;

endpackage

// ===== rtl/u8dec_step.sv =====
`timescale 1ns / 1ps

module u8dec_step #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  u8dec_pkg::req_type                     req,
   input  u8dec_pkg::seq_state_type               seq_state,
   input  logic [COUNT_BITS-1:0]                  emitted_count,
   input  logic [u8dec_pkg::MAX_CHAR_BITS-1:0]    max_chars,
   output u8dec_pkg::seq_state_type               seq_state_next,
   output logic [COUNT_BITS-1:0]                  emitted_count_next,
   output u8dec_pkg::rsp_type                     rsp,
   output logic                                   rsp_fire
);

   localparam int unsigned CMP_BITS =
      (COUNT_BITS > u8dec_pkg::MAX_CHAR_BITS) ? COUNT_BITS : u8dec_pkg::MAX_CHAR_BITS;

   logic [u8dec_pkg::BYTE_BITS-1:0] b;
   logic                            done;
   logic                            limit_hit;
   logic [CMP_BITS-1:0]             count_wide;
   logic [COUNT_BITS-1:0]           count_upd;
   u8dec_pkg::seq_state_type        st;

   assign b = req.in_byte;
   assign limit_hit = (max_chars != '0) &&
                      (CMP_BITS'(emitted_count) >= CMP_BITS'(max_chars));

   always_comb begin
      st   = seq_state;
      done = 1'b0;
      if (seq_state.bytes_left != u8dec_pkg::LEFT_NONE) begin
         st.accumulator = {seq_state.accumulator[u8dec_pkg::CP_BITS-u8dec_pkg::CONT_BITS-1:0],
                           b[u8dec_pkg::CONT_BITS-1:0]};
         st.bytes_left  = seq_state.bytes_left - u8dec_pkg::LEFT_BITS'(1);
         done           = (seq_state.bytes_left == u8dec_pkg::LEFT_TWO);
      end else if (!seq_state.stopped && limit_hit) begin
         st.stopped = 1'b1;
      end else if (!seq_state.stopped) begin
         unique case (b) inside
            8'b0???????: begin
               st.accumulator = u8dec_pkg::CP_BITS'(b);
               done           = 1'b1;
            end
            8'b110?????: begin
               st.accumulator = u8dec_pkg::CP_BITS'(b[4:0]);
               st.bytes_left  = u8dec_pkg::LEFT_TWO;
            end
            8'b1110????: begin
               st.accumulator = u8dec_pkg::CP_BITS'(b[3:0]);
               st.bytes_left  = u8dec_pkg::LEFT_THREE;
            end
            8'b11110???: begin
               st.accumulator = u8dec_pkg::CP_BITS'(b[2:0]);
               st.bytes_left  = u8dec_pkg::LEFT_FOUR;
            end
            default: begin
               st.accumulator = u8dec_pkg::CP_BITS'(b[1:0]);
               st.bytes_left  = u8dec_pkg::LEFT_FIVE;
            end
         endcase
      end
   end

   // saturating per-string count
   assign count_upd  = (done && (emitted_count != '1)) ?
                       emitted_count + COUNT_BITS'(1) : emitted_count;
   assign count_wide = CMP_BITS'(count_upd);

   always_comb begin
      rsp.code_point = done ? st.accumulator : '0;
      rsp.char_valid = done;
      rsp.last       = req.end_of_string;
      rsp.char_count = (count_wide > CMP_BITS'(u8dec_pkg::OUT_COUNT_MAX)) ?
                       u8dec_pkg::OUT_COUNT_MAX : count_wide[u8dec_pkg::OUT_COUNT_BITS-1:0];
      rsp_fire       = done || req.end_of_string;

      seq_state_next = st;
      if (done) begin
         seq_state_next.accumulator = '0;
      end
      emitted_count_next = count_upd;
      if (req.end_of_string) begin
         seq_state_next     = '0;
         emitted_count_next = '0;
      end
   end

endmodule

// ===== rtl/utf8_to_code_point_decoder.sv =====
`timescale 1ns / 1ps

// UTF-8 decoder: takes one byte per req beat, with end_of_string on the final
// byte, and returns one rsp beat per completed code point or final byte; the
// final byte's beat carries last and the string's code point count. Lead bytes
// 0xxxxxxx, 110xxxxx, 1110xxxx and 11110xxx open 1- to 4-byte sequences, any
// other lead opens a 5-byte sequence; continuation bytes give their low six
// bits unchecked. A truncated sequence at the end is dropped. A nonzero
// max_chars (csr) stops decoding for the rest of the string once reached.
// Throughput is one byte per cycle while req_ready is high; results leave from
// the output register. A two-entry output stage (output register plus skid
// register) keeps req_ready registered: req_ready falls only while the skid
// register holds a beat, which happens once a new result arrives while the
// output register holds a beat and rsp_ready is low.

module utf8_to_code_point_decoder #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  u8dec_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output u8dec_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [u8dec_pkg::MAX_CHAR_BITS-1:0] csr_data
);

   logic [u8dec_pkg::MAX_CHAR_BITS-1:0] max_chars_ff;
   u8dec_pkg::seq_state_type            seq_state_ff, seq_state_in;
   logic [COUNT_BITS-1:0]               emitted_ff, emitted_in;
   logic                                out_valid_ff, out_valid_in;
   u8dec_pkg::rsp_type                  out_data_ff, out_data_in;
   logic                                skid_valid_ff, skid_valid_in;
   u8dec_pkg::rsp_type                  skid_data_ff, skid_data_in;

   u8dec_pkg::seq_state_type            step_state;
   logic [COUNT_BITS-1:0]               step_emitted;
   u8dec_pkg::rsp_type                  step_rsp;
   logic                                step_fire;
   logic                                req_accept;
   logic                                fire;
   logic                                out_free;

   u8dec_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .req                (req_data),
      .seq_state          (seq_state_ff),
      .emitted_count      (emitted_ff),
      .max_chars          (max_chars_ff),
      .seq_state_next     (step_state),
      .emitted_count_next (step_emitted),
      .rsp                (step_rsp),
      .rsp_fire           (step_fire)
   );

   assign req_ready  = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;
   assign req_accept = req_valid && req_ready;
   assign fire       = req_accept && step_fire;
   assign out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      seq_state_in  = req_accept ? step_state : seq_state_ff;
      emitted_in    = req_accept ? step_emitted : emitted_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = fire;
            skid_data_in  = step_rsp;
         end else begin
            out_valid_in = fire;
            out_data_in  = step_rsp;
         end
      end else if (fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff  <= '0;
         seq_state_ff  <= '0;
         emitted_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_chars_ff <= csr_data;
         end
         seq_state_ff  <= seq_state_in;
         emitted_ff    <= emitted_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef NO_ASSERTIONS
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while output register is empty");

   a_idle_cp_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.char_valid) |-> (out_data_ff.code_point == '0))
      else $error("code point nonzero on a beat without a character");

   a_mid_string_has_char : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.last) |-> out_data_ff.char_valid)
      else $error("mid-string beat without a character");

   a_string_clear : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.end_of_string) |=>
         (seq_state_ff == '0) && (emitted_ff == '0))
      else $error("string state not cleared after final byte");
`endif

endmodule
